[src/phsm_pkg.sv]
// ----------------------------------------------------------------------------
// Pointer homing step mover package
// Shared word types, configuration and state records, and command codes.
// ----------------------------------------------------------------------------
package phsm_pkg;

    localparam logic [1:0] KIND_SET_TARGET = 2'd0;
    localparam logic [1:0] KIND_STEP       = 2'd1;
    localparam logic [1:0] KIND_HOME       = 2'd2;

    localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
    localparam logic [1:0] REG_SCALE_Q8      = 2'd2;
    localparam logic [1:0] REG_MAX_JUMP      = 2'd3;

    localparam logic [12:0] SCREEN_WIDTH_RESET  = 13'd3840;
    localparam logic [12:0] SCREEN_HEIGHT_RESET = 13'd2160;
    localparam logic [9:0]  SCALE_Q8_RESET      = 10'd256;
    localparam logic [6:0]  MAX_JUMP_RESET      = 7'd10;

    localparam logic signed [17:0] HOME_OVERSHOOT = 18'sd50;

    typedef struct packed {
        logic [1:0]  kind;
        logic [13:0] goal_x;
        logic [13:0] goal_y;
        logic        home_first;
    } in_word_t;

    typedef struct packed {
        logic              move_valid;
        logic signed [7:0] delta_x;
        logic signed [7:0] delta_y;
        logic              arrived;
    } out_word_t;

    typedef struct packed {
        logic [12:0] screen_width;
        logic [12:0] screen_height;
        logic [9:0]  scale_q8;
        logic [6:0]  max_jump;
    } phsm_cfg_t;

    typedef struct packed {
        logic [15:0]        aim_x;
        logic [15:0]        aim_y;
        logic signed [17:0] pos_x;
        logic signed [17:0] pos_y;
        logic               is_homed;
        logic               turn_is_x;
    } phsm_state_t;

endpackage

[src/phsm_core.sv]
// ----------------------------------------------------------------------------
// Pointer homing step mover core
// Computes the result word and the next position state for one command word.
// ----------------------------------------------------------------------------
module phsm_core
    import phsm_pkg::*;
(
    input  in_word_t    cmd,
    input  phsm_cfg_t   cfg,
    input  phsm_state_t state,
    output phsm_state_t state_next,
    output out_word_t   result
);

    function automatic logic signed [7:0] clamp_step(
        input logic signed [18:0] diff,
        input logic [6:0]         jump
    );
        logic signed [18:0] lim;
        begin
            lim = $signed({12'd0, jump});
            if (diff > lim)
            begin
                clamp_step = $signed({1'b0, jump});
            end
            else if (diff < -lim)
            begin
                clamp_step = -$signed({1'b0, jump});
            end
            else
            begin
                clamp_step = diff[7:0];
            end
        end
    endfunction

    logic [23:0]        prod_x;
    logic [23:0]        prod_y;
    logic [6:0]         jump;
    logic signed [17:0] tx;
    logic signed [17:0] ty;
    logic signed [18:0] diff_x;
    logic signed [18:0] diff_y;
    logic signed [7:0]  dx;
    logic signed [7:0]  dy;
    logic               ne_x;
    logic               ne_y;

    assign prod_x = {10'd0, cmd.goal_x} * {14'd0, cfg.scale_q8};
    assign prod_y = {10'd0, cmd.goal_y} * {14'd0, cfg.scale_q8};
    assign jump   = (cfg.max_jump == 7'd0) ? 7'd1 : cfg.max_jump;

    always_comb
    begin
        if (state.is_homed)
        begin
            tx = $signed({2'b00, state.aim_x});
            ty = $signed({2'b00, state.aim_y});
        end
        else
        begin
            tx = -$signed({5'd0, cfg.screen_width}) - HOME_OVERSHOOT;
            ty = -$signed({5'd0, cfg.screen_height}) - HOME_OVERSHOOT;
        end
    end

    assign diff_x = {tx[17], tx} - {state.pos_x[17], state.pos_x};
    assign diff_y = {ty[17], ty} - {state.pos_y[17], state.pos_y};
    assign dx     = clamp_step(diff_x, jump);
    assign dy     = clamp_step(diff_y, jump);
    assign ne_x   = (state.pos_x != tx);
    assign ne_y   = (state.pos_y != ty);

    always_comb
    begin
        state_next = state;
        result     = '0;
        case (cmd.kind)
            KIND_SET_TARGET:
            begin
                state_next.aim_x    = prod_x[23:8];
                state_next.aim_y    = prod_y[23:8];
                state_next.is_homed = ~cmd.home_first;
            end
            KIND_HOME:
            begin
                state_next.is_homed = 1'b0;
            end
            KIND_STEP:
            begin
                if (ne_x || ne_y)
                begin
                    result.move_valid = 1'b1;
                    if (ne_x && (!ne_y || state.turn_is_x))
                    begin
                        result.delta_x       = dx;
                        state_next.pos_x     = state.pos_x + {{10{dx[7]}}, dx};
                        state_next.turn_is_x = 1'b0;
                    end
                    else
                    begin
                        result.delta_y       = dy;
                        state_next.pos_y     = state.pos_y + {{10{dy[7]}}, dy};
                        state_next.turn_is_x = 1'b1;
                    end
                end
                else if (!state.is_homed)
                begin
                    state_next.is_homed = 1'b1;
                    state_next.pos_x    = '0;
                    state_next.pos_y    = '0;
                end
                else
                begin
                    state_next.is_homed = 1'b0;
                    result.arrived      = 1'b1;
                end
            end
            default:
            begin
                state_next = state;
            end
        endcase
    end

endmodule

[src/pointer_homing_step_mover.sv]
// ----------------------------------------------------------------------------
// Pointer homing step mover
// Turns target, step and homing commands into single-axis relative moves.
// ----------------------------------------------------------------------------
//  channel   signals                          direction
//  in        in_valid, in_ready, in_word      command words in
//  out       out_valid, out_ready, out_word   one result word per command
//  cfg       cfg_write, cfg_index, cfg_data   register writes, no wait
//
// A command word is taken into an input register; from there the core updates
// the position state and loads the result register, so one word passes per
// cycle while the result is not stalled. A stalled result holds the result
// register; the input register refills only as it drains. Reset clears
// the position state and loads the register defaults.
// ----------------------------------------------------------------------------
module pointer_homing_step_mover
    import phsm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_word_t    in_word,
    output logic        out_valid,
    input  logic        out_ready,
    output out_word_t   out_word,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data
);

    phsm_cfg_t   cfg_reg;
    phsm_state_t state_reg;
    phsm_state_t state_next;
    in_word_t    cmd_reg;
    logic        cmd_full_reg;
    out_word_t   res_reg;
    out_word_t   res_next;
    logic        res_full_reg;
    logic        advance;

    assign advance  = cmd_full_reg && (!res_full_reg || out_ready);
    assign in_ready = !cmd_full_reg || advance;

    phsm_core u_core (
        .cmd        (cmd_reg),
        .cfg        (cfg_reg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.screen_width  <= SCREEN_WIDTH_RESET;
            cfg_reg.screen_height <= SCREEN_HEIGHT_RESET;
            cfg_reg.scale_q8      <= SCALE_Q8_RESET;
            cfg_reg.max_jump      <= MAX_JUMP_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_SCREEN_WIDTH:  cfg_reg.screen_width  <= cfg_data;
                REG_SCREEN_HEIGHT: cfg_reg.screen_height <= cfg_data;
                REG_SCALE_Q8:      cfg_reg.scale_q8      <= cfg_data[9:0];
                REG_MAX_JUMP:      cfg_reg.max_jump      <= cfg_data[6:0];
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= '0;
            cmd_full_reg <= 1'b0;
            res_full_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                cmd_full_reg <= in_valid;
            end
            if (advance)
            begin
                state_reg    <= state_next;
                res_full_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                res_full_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            cmd_reg <= in_word;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = res_full_reg;
    assign out_word  = res_reg;

endmodule

[src/phsm_checker.sv]
// ----------------------------------------------------------------------------
// Pointer homing step mover checker
// Port-level assertions on the result words, bound to the top level.
// ----------------------------------------------------------------------------
module phsm_checker
    import phsm_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      out_valid,
    input logic      out_ready,
    input out_word_t out_word
);

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("Stalled result word changed or dropped.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.move_valid |->
            ((out_word.delta_x != 8'sd0) != (out_word.delta_y != 8'sd0)))
    else $error("A move must change exactly one axis.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_word.move_valid |->
            out_word.delta_x == 8'sd0 && out_word.delta_y == 8'sd0)
    else $error("A word without a move carries nonzero deltas.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.arrived |-> !out_word.move_valid)
    else $error("Arrival reported together with a move.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_word.delta_x != -8'sd128 && out_word.delta_y != -8'sd128)
    else $error("Delta beyond the largest jump.");

endmodule

bind pointer_homing_step_mover phsm_checker u_phsm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
);
